@@ rtl/rdc_pkg.sv @@
// rdc_pkg: shared constants and the digit-to-ascii function of the
// radix digit converter; no dependencies

package rdc_pkg;

    localparam int VALUE_W         = 63;
    localparam int S_TDATA_W       = 64;
    localparam int RADIX_W         = 5;
    localparam int DIGIT_W         = 4;
    localparam int CHAR_W          = 7;
    localparam int M_TDATA_W       = 8;
    localparam int MAX_DIGITS      = 64;
    localparam int ADDR_W          = $clog2(MAX_DIGITS);
    localparam int COUNT_W         = $clog2(MAX_DIGITS + 1);
    localparam int WORK_W          = 64;
    localparam int STEP_BITS       = 8;
    localparam int STEPS_PER_DIGIT = WORK_W / STEP_BITS;
    localparam int STEP_CNT_W      = $clog2(STEPS_PER_DIGIT);
    localparam int REM_W           = DIGIT_W + 1;

    localparam logic [RADIX_W-1:0] RADIX_DEFAULT = RADIX_W'(10);
    localparam logic [RADIX_W-1:0] RADIX_MIN     = RADIX_W'(2);
    localparam logic [RADIX_W-1:0] RADIX_MAX     = RADIX_W'(16);
    localparam logic [DIGIT_W-1:0] DECIMAL_LIMIT = DIGIT_W'(10);
    localparam logic [CHAR_W-1:0]  CHAR_ZERO     = CHAR_W'(8'h30);
    localparam logic [CHAR_W-1:0]  CHAR_A        = CHAR_W'(8'h41);
    localparam logic [CHAR_W-1:0]  CHAR_NINE     = CHAR_W'(8'h39);
    localparam logic [CHAR_W-1:0]  CHAR_F        = CHAR_W'(8'h46);

    function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d < DECIMAL_LIMIT) begin
            c = CHAR_ZERO + CHAR_W'(d);
        end else begin
            c = CHAR_A + CHAR_W'(d - DECIMAL_LIMIT);
        end
        return c;
    endfunction

endpackage

@@ rtl/rdc_ram.sv @@
// rdc_ram: generic single write port, single read port ram with registered read
// no dependencies

module rdc_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/radix_digit_converter.sv @@
// radix_digit_converter: converts a non-negative integer to ascii digits in base 2..16
// depends on rdc_pkg and rdc_ram
//
// usage:
//   s_ channel: one transaction carries the value to convert (s_tdata[62:0]).
//   m_ channel: one transaction per digit, ascii '0'-'9'/'A'-'F' in m_tdata[6:0],
//   most significant digit first, m_tlast on the least significant digit.
//   cfg_wen/cfg_wdata write the radix; values outside 2..16 store 10. write only
//   while the block is idle.
// operation:
//   each digit takes a full pass of the shared divider over a 64-bit word (8 quotient
//   bits per cycle). digits then leave one at a time after the last division step:
//   each is read from the digit store, then loaded into the output register, before
//   another is read. a value has at most 63 digits (base 2).
//   s_tready is high only while no conversion is running; the next value can be
//   taken while the final digit still waits in the output register.
// reset: aresetn low returns to idle, drops m_tvalid and sets the radix to 10.
// stall: a low m_tready holds the output register and pauses the digit readout.

module radix_digit_converter (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wen,
    input  logic [rdc_pkg::RADIX_W-1:0]   cfg_wdata,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [rdc_pkg::S_TDATA_W-1:0] s_tdata,   // [62:0] value
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [rdc_pkg::M_TDATA_W-1:0] m_tdata,   // [6:0] digit_char
    output logic                          m_tlast
);

    import rdc_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_RD,
        S_LOAD
    } state_t;

    state_t                state_reg, state_next;
    logic [RADIX_W-1:0]    radix_reg, radix_next;
    logic [WORK_W-1:0]     work_reg, work_next;
    logic [REM_W-1:0]      rem_reg, rem_next;
    logic [STEP_CNT_W-1:0] step_reg, step_next;
    logic [COUNT_W-1:0]    count_reg, count_next;
    logic [ADDR_W-1:0]     rd_addr_reg, rd_addr_next;
    logic                  m_tvalid_reg, m_tvalid_next;
    logic [CHAR_W-1:0]     m_char_reg, m_char_next;
    logic                  m_tlast_reg, m_tlast_next;

    logic [REM_W-1:0]      div_rem;
    logic [STEP_BITS-1:0]  div_quo;
    logic [WORK_W-1:0]     quotient;
    logic                  digit_done;
    logic                  ram_we;
    logic                  ram_re;
    logic [DIGIT_W-1:0]    ram_rdata;

    // shared divider slice: 8 restoring steps on the narrow remainder
    always_comb begin
        div_rem = rem_reg;
        div_quo = '0;
        for (int i = 0; i < STEP_BITS; i++) begin
            div_rem = {div_rem[REM_W-2:0], work_reg[WORK_W-1-i]};
            if (div_rem >= radix_reg) begin
                div_rem = div_rem - radix_reg;
                div_quo[STEP_BITS-1-i] = 1'b1;
            end
        end
    end

    assign quotient   = {work_reg[WORK_W-STEP_BITS-1:0], div_quo};
    assign digit_done = (state_reg == S_DIV) && (step_reg == STEP_CNT_W'(STEPS_PER_DIGIT - 1));
    assign ram_we     = digit_done;
    assign ram_re     = (state_reg == S_RD);

    rdc_ram #(
        .WIDTH (DIGIT_W),
        .DEPTH (MAX_DIGITS)
    ) u_digit_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (count_reg[ADDR_W-1:0]),
        .wdata (div_rem[DIGIT_W-1:0]),
        .re    (ram_re),
        .raddr (rd_addr_reg),
        .rdata (ram_rdata)
    );

    always_comb begin
        state_next    = state_reg;
        radix_next    = radix_reg;
        work_next     = work_reg;
        rem_next      = rem_reg;
        step_next     = step_reg;
        count_next    = count_reg;
        rd_addr_next  = rd_addr_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_char_next   = m_char_reg;
        m_tlast_next  = m_tlast_reg;

        if (cfg_wen) begin
            if (cfg_wdata < RADIX_MIN || cfg_wdata > RADIX_MAX) begin
                radix_next = RADIX_DEFAULT;
            end else begin
                radix_next = cfg_wdata;
            end
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    work_next  = {1'b0, s_tdata[VALUE_W-1:0]};
                    rem_next   = '0;
                    step_next  = '0;
                    count_next = '0;
                    state_next = S_DIV;
                end
            end
            S_DIV: begin
                step_next = step_reg + STEP_CNT_W'(1);
                if (digit_done) begin
                    work_next  = quotient;
                    rem_next   = '0;
                    count_next = count_reg + COUNT_W'(1);
                    if (quotient == '0 || count_reg == COUNT_W'(MAX_DIGITS - 1)) begin
                        rd_addr_next = count_reg[ADDR_W-1:0];
                        state_next   = S_RD;
                    end
                end else begin
                    work_next = quotient;
                    rem_next  = div_rem;
                end
            end
            S_RD: begin
                state_next = S_LOAD;
            end
            S_LOAD: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_char_next   = digit_to_ascii(ram_rdata);
                    m_tlast_next  = (rd_addr_reg == '0);
                    if (rd_addr_reg == '0) begin
                        count_next = '0;
                        state_next = S_IDLE;
                    end else begin
                        rd_addr_next = rd_addr_reg - ADDR_W'(1);
                        state_next   = S_RD;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            radix_reg    <= RADIX_DEFAULT;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            radix_reg    <= radix_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        work_reg    <= work_next;
        rem_reg     <= rem_next;
        step_reg    <= step_next;
        rd_addr_reg <= rd_addr_next;
        m_char_reg  <= m_char_next;
        m_tlast_reg <= m_tlast_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, m_char_reg};
    assign m_tlast  = m_tlast_reg;

endmodule

@@ rtl/rdc_checker.sv @@
// rdc_checker: port-level checks of radix_digit_converter and its bind
// depends on rdc_pkg

module rdc_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [rdc_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                          m_tlast
);

    import rdc_pkg::*;

    // a stalled result holds
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("m_ transaction changed while stalled");

    // every result is a legal digit character
    a_m_char: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[M_TDATA_W-1] == 1'b0) &&
            ((m_tdata[CHAR_W-1:0] >= CHAR_ZERO && m_tdata[CHAR_W-1:0] <= CHAR_NINE) ||
             (m_tdata[CHAR_W-1:0] >= CHAR_A && m_tdata[CHAR_W-1:0] <= CHAR_F)))
        else $error("m_tdata is not a digit character");

    // busy right after taking a value
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("s_tready high right after accepting a value");

    // a waiting non-final digit means the run is still in progress
    a_busy_mid_run: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("s_tready high before the final digit was produced");

    // reset empties the output
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("m_tvalid high after reset");

endmodule

bind radix_digit_converter rdc_checker u_rdc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
